### rtl/adpcm_enc_pkg.sv
// ----------------------------------------------------------------------------
// adpcm_enc_pkg
// Shared types, codes and step tables of the four-bit ADPCM sample encoder.
// ----------------------------------------------------------------------------
package adpcm_enc_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic        [3:0]  code_t;
  typedef logic        [15:0] step_t;
  typedef logic        [1:0]  cfg_idx_t;
  typedef logic signed [10:0] cfg_data_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_MODE        = 2'd0;
  localparam cfg_idx_t REG_COEF_FIRST  = 2'd1;
  localparam cfg_idx_t REG_COEF_SECOND = 2'd2;

  // Input commands
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    MODE_IMA_DIV = 2'd0,
    MODE_IMA_SAR = 2'd1,
    MODE_TWO_TAP = 2'd2,
    MODE_SCALE   = 2'd3
  } mode_t;

  localparam logic [6:0]  IDX_MAX     = 7'd88;
  localparam step_t       DELTA_MIN   = 16'd16;
  localparam step_t       SCALE_MIN   = 16'd127;
  localparam step_t       SCALE_MAX   = 16'd24567;
  localparam logic signed [15:0] COEF_FIRST_RST = 16'sd256;

  function automatic step_t ima_step(input logic [6:0] idx);
    step_t s;
    case (idx)
      7'd0: s = 16'd7;       7'd1: s = 16'd8;       7'd2: s = 16'd9;
      7'd3: s = 16'd10;      7'd4: s = 16'd11;      7'd5: s = 16'd12;
      7'd6: s = 16'd13;      7'd7: s = 16'd14;      7'd8: s = 16'd16;
      7'd9: s = 16'd17;      7'd10: s = 16'd19;     7'd11: s = 16'd21;
      7'd12: s = 16'd23;     7'd13: s = 16'd25;     7'd14: s = 16'd28;
      7'd15: s = 16'd31;     7'd16: s = 16'd34;     7'd17: s = 16'd37;
      7'd18: s = 16'd41;     7'd19: s = 16'd45;     7'd20: s = 16'd50;
      7'd21: s = 16'd55;     7'd22: s = 16'd60;     7'd23: s = 16'd66;
      7'd24: s = 16'd73;     7'd25: s = 16'd80;     7'd26: s = 16'd88;
      7'd27: s = 16'd97;     7'd28: s = 16'd107;    7'd29: s = 16'd118;
      7'd30: s = 16'd130;    7'd31: s = 16'd143;    7'd32: s = 16'd157;
      7'd33: s = 16'd173;    7'd34: s = 16'd190;    7'd35: s = 16'd209;
      7'd36: s = 16'd230;    7'd37: s = 16'd253;    7'd38: s = 16'd279;
      7'd39: s = 16'd307;    7'd40: s = 16'd337;    7'd41: s = 16'd371;
      7'd42: s = 16'd408;    7'd43: s = 16'd449;    7'd44: s = 16'd494;
      7'd45: s = 16'd544;    7'd46: s = 16'd598;    7'd47: s = 16'd658;
      7'd48: s = 16'd724;    7'd49: s = 16'd796;    7'd50: s = 16'd876;
      7'd51: s = 16'd963;    7'd52: s = 16'd1060;   7'd53: s = 16'd1166;
      7'd54: s = 16'd1282;   7'd55: s = 16'd1411;   7'd56: s = 16'd1552;
      7'd57: s = 16'd1707;   7'd58: s = 16'd1878;   7'd59: s = 16'd2066;
      7'd60: s = 16'd2272;   7'd61: s = 16'd2499;   7'd62: s = 16'd2749;
      7'd63: s = 16'd3024;   7'd64: s = 16'd3327;   7'd65: s = 16'd3660;
      7'd66: s = 16'd4026;   7'd67: s = 16'd4428;   7'd68: s = 16'd4871;
      7'd69: s = 16'd5358;   7'd70: s = 16'd5894;   7'd71: s = 16'd6484;
      7'd72: s = 16'd7132;   7'd73: s = 16'd7845;   7'd74: s = 16'd8630;
      7'd75: s = 16'd9493;   7'd76: s = 16'd10442;  7'd77: s = 16'd11487;
      7'd78: s = 16'd12635;  7'd79: s = 16'd13899;  7'd80: s = 16'd15289;
      7'd81: s = 16'd16818;  7'd82: s = 16'd18500;  7'd83: s = 16'd20350;
      7'd84: s = 16'd22385;  7'd85: s = 16'd24623;  7'd86: s = 16'd27086;
      7'd87: s = 16'd29794;
      default: s = 16'd32767;
    endcase
    return s;
  endfunction

  // Multiplier (x256) for the step-scaling mode
  function automatic logic [9:0] scale_mul(input code_t code);
    logic [9:0] m;
    case (code[2:0])
      3'd4: m = 10'd307;
      3'd5: m = 10'd409;
      3'd6: m = 10'd512;
      3'd7: m = 10'd614;
      default: m = 10'd230;
    endcase
    return m;
  endfunction

  // Multiplier (x256) for the two-tap mode delta
  function automatic logic [9:0] adapt_mul(input code_t code);
    logic [9:0] m;
    case (code)
      4'd4:  m = 10'd307;
      4'd5:  m = 10'd409;
      4'd6:  m = 10'd512;
      4'd7:  m = 10'd614;
      4'd8:  m = 10'd768;
      4'd9:  m = 10'd614;
      4'd10: m = 10'd512;
      4'd11: m = 10'd409;
      4'd12: m = 10'd307;
      default: m = 10'd230;
    endcase
    return m;
  endfunction

  function automatic sample_t sat16(input logic signed [20:0] v);
    sample_t r;
    if (v > 21'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### rtl/adpcm_enc_in_if.sv
// ----------------------------------------------------------------------------
// adpcm_enc_in_if
// Sample channel into the encoder: command, channel and PCM sample.
// ----------------------------------------------------------------------------
interface adpcm_enc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic                      channel;
  adpcm_enc_pkg::sample_t    pcm_sample;

  modport source (output valid, command, channel, pcm_sample, input ready);
  modport sink   (input valid, command, channel, pcm_sample, output ready);
endinterface

### rtl/adpcm_enc_out_if.sv
// ----------------------------------------------------------------------------
// adpcm_enc_out_if
// Result channel out of the encoder: code, reconstruction and step.
// ----------------------------------------------------------------------------
interface adpcm_enc_out_if;
  logic                      valid;
  logic                      ready;
  adpcm_enc_pkg::code_t      code_nibble;
  adpcm_enc_pkg::sample_t    reconstructed;
  adpcm_enc_pkg::step_t      step_value;

  modport source (output valid, code_nibble, reconstructed, step_value, input ready);
  modport sink   (input valid, code_nibble, reconstructed, step_value, output ready);
endinterface

### rtl/adpcm_enc_cfg_if.sv
// ----------------------------------------------------------------------------
// adpcm_enc_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface adpcm_enc_cfg_if;
  logic                       valid;
  logic                       ready;
  adpcm_enc_pkg::cfg_idx_t    reg_index;
  adpcm_enc_pkg::cfg_data_t   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/adpcm_sample_encoder.sv
// ----------------------------------------------------------------------------
// adpcm_sample_encoder
// Per-channel four-bit ADPCM encoder with four coding modes.
// ----------------------------------------------------------------------------
// One sample beat goes in, one result beat comes out. The block works on one
// beat at a time. A load or an out-of-range channel goes from fetch straight
// to write-back; an encode passes through a four-step compare-subtract
// quotient unit and one shared 18x12 multiplier that every product goes
// through in turn.
// A finished result waits in the output register; the block stalls in write-
// back only when the previous result has not yet been taken. The register
// port is always ready and must only be written while the block is idle.
module adpcm_sample_encoder #(
  parameter int CHANNELS = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  adpcm_enc_cfg_if.sink             cfg,
  adpcm_enc_in_if.sink              sample_in,
  adpcm_enc_out_if.source           code_out
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_FETCH = 15'b000000000000010,
    ST_PREP  = 15'b000000000000100,
    ST_PRED1 = 15'b000000000001000,
    ST_PRED2 = 15'b000000000010000,
    ST_PRED3 = 15'b000000000100000,
    ST_PRED4 = 15'b000000001000000,
    ST_ERR   = 15'b000000010000000,
    ST_DIV   = 15'b000000100000000,
    ST_CODE  = 15'b000001000000000,
    ST_MUL1  = 15'b000010000000000,
    ST_RECON = 15'b000100000000000,
    ST_MUL2  = 15'b001000000000000,
    ST_STEP  = 15'b010000000000000,
    ST_WB    = 15'b100000000000000
  } state_t;

  state_t state;

  adpcm_enc_pkg::mode_t       mode;
  adpcm_enc_pkg::cfg_data_t   coef_first;
  adpcm_enc_pkg::cfg_data_t   coef_second;

  adpcm_enc_pkg::sample_t     recon_mem [CHANNELS];
  adpcm_enc_pkg::sample_t     older_mem [CHANNELS];
  adpcm_enc_pkg::step_t       step_mem  [CHANNELS];

  logic                       cmd;
  logic                       chan;
  adpcm_enc_pkg::sample_t     smp;
  logic                       zero_out;

  adpcm_enc_pkg::sample_t     w_rec;
  adpcm_enc_pkg::sample_t     w_old;
  adpcm_enc_pkg::step_t       w_st;
  adpcm_enc_pkg::step_t       dvs;
  logic                       neg;
  logic [15:0]                mag;
  logic [19:0]                rem;
  logic [19:0]                dv;
  logic [3:0]                 qb;
  logic [1:0]                 cnt;
  adpcm_enc_pkg::code_t       code;
  logic signed [4:0]          qs;
  logic signed [26:0]         acc;
  logic signed [18:0]         pred;
  logic signed [29:0]         mul_q;

  logic [IDX_W-1:0]           ch_idx;
  logic                       in_range;
  logic                       wb_go;
  logic [6:0]                 idx;
  adpcm_enc_pkg::step_t       d_sel;
  logic signed [16:0]         delta;
  logic [15:0]                delta_mag;
  logic signed [19:0]         err;
  logic [18:0]                err_mag;
  logic                       ge;
  logic [3:0]                 qmag;
  logic signed [17:0]         mul_a;
  logic signed [11:0]         mul_b;
  logic [17:0]                diff;
  logic signed [20:0]         rsum;
  logic signed [8:0]          idx_sum;
  logic [6:0]                 idx_new;
  logic [21:0]                nd;
  adpcm_enc_pkg::step_t       st_new;
  logic signed [26:0]         acc_neg;

  assign ch_idx   = IDX_W'(chan);
  assign in_range = (32'(chan) < CHANNELS);
  assign wb_go    = !code_out.valid || code_out.ready;

  assign sample_in.ready = (state == ST_IDLE);
  assign cfg.ready       = 1'b1;

  // Operand selection and per-state arithmetic
  always_comb begin
    idx = (w_st > 16'(adpcm_enc_pkg::IDX_MAX)) ? adpcm_enc_pkg::IDX_MAX : w_st[6:0];
    unique case (mode) inside
      adpcm_enc_pkg::MODE_IMA_DIV, adpcm_enc_pkg::MODE_IMA_SAR: begin
        d_sel = adpcm_enc_pkg::ima_step(idx);
      end
      adpcm_enc_pkg::MODE_TWO_TAP: begin
        d_sel = (w_st < adpcm_enc_pkg::DELTA_MIN) ? adpcm_enc_pkg::DELTA_MIN : w_st;
      end
      default: begin
        d_sel = w_st;
      end
    endcase

    delta     = {smp[15], smp} - {w_rec[15], w_rec};
    delta_mag = delta[16] ? 16'(-delta) : delta[15:0];
    err       = 20'(smp) - 20'(pred);
    err_mag   = err[19] ? 19'(-err) : err[18:0];

    ge = (rem >= dv) && !((mode == adpcm_enc_pkg::MODE_IMA_SAR) && (cnt == 2'd0));

    if (qb[3]) begin
      qmag = neg ? 4'd8 : 4'd7;
    end else begin
      qmag = {1'b0, qb[2:0]};
    end

    // Shared multiplier operands
    mul_a = {2'b00, dvs};
    mul_b = {8'd0, code[2:0], 1'b1};
    case (state)
      ST_PRED1: begin
        mul_a = 18'(w_rec);
        mul_b = 12'(coef_first);
      end
      ST_PRED2: begin
        mul_a = 18'(w_old);
        mul_b = 12'(coef_second);
      end
      ST_MUL1: begin
        if (mode == adpcm_enc_pkg::MODE_TWO_TAP) begin
          mul_b = 12'(qs);
        end
      end
      ST_MUL2: begin
        if (mode == adpcm_enc_pkg::MODE_TWO_TAP) begin
          mul_b = {2'b00, adpcm_enc_pkg::adapt_mul(code)};
        end else begin
          mul_b = {2'b00, adpcm_enc_pkg::scale_mul(code)};
        end
      end
      default: begin
      end
    endcase

    acc_neg = -acc;

    diff = {2'b00, mag} + 18'(dvs >> 3) - rem[17:0];
    unique case (mode) inside
      adpcm_enc_pkg::MODE_IMA_SAR: begin
        rsum = code[3] ? 21'(w_rec) - 21'(diff) : 21'(w_rec) + 21'(diff);
      end
      adpcm_enc_pkg::MODE_TWO_TAP: begin
        rsum = 21'(pred) + mul_q[20:0];
      end
      default: begin
        rsum = code[3] ? 21'(w_rec) - 21'(mul_q[20:3]) : 21'(w_rec) + 21'(mul_q[20:3]);
      end
    endcase

    if (code[2]) begin
      idx_sum = 9'(idx) + 9'({code[1:0], 1'b0}) + 9'sd2;
    end else begin
      idx_sum = 9'(idx) - 9'sd1;
    end
    if (idx_sum < 9'sd0) begin
      idx_new = 7'd0;
    end else if (idx_sum > 9'(adpcm_enc_pkg::IDX_MAX)) begin
      idx_new = adpcm_enc_pkg::IDX_MAX;
    end else begin
      idx_new = idx_sum[6:0];
    end

    nd = mul_q[29:8];
    if (mode == adpcm_enc_pkg::MODE_TWO_TAP) begin
      if (nd < 22'(adpcm_enc_pkg::DELTA_MIN)) begin
        st_new = adpcm_enc_pkg::DELTA_MIN;
      end else if (nd > 22'hFFFF) begin
        st_new = 16'hFFFF;
      end else begin
        st_new = nd[15:0];
      end
    end else begin
      if (nd < 22'(adpcm_enc_pkg::SCALE_MIN)) begin
        st_new = adpcm_enc_pkg::SCALE_MIN;
      end else if (nd > 22'(adpcm_enc_pkg::SCALE_MAX)) begin
        st_new = adpcm_enc_pkg::SCALE_MAX;
      end else begin
        st_new = nd[15:0];
      end
    end
  end

  // Register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= adpcm_enc_pkg::MODE_IMA_DIV;
      coef_first  <= 11'(adpcm_enc_pkg::COEF_FIRST_RST);
      coef_second <= '0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        adpcm_enc_pkg::REG_MODE:        mode        <= adpcm_enc_pkg::mode_t'(cfg.wdata[1:0]);
        adpcm_enc_pkg::REG_COEF_FIRST:  coef_first  <= cfg.wdata;
        adpcm_enc_pkg::REG_COEF_SECOND: coef_second <= cfg.wdata;
        default: begin
        end
      endcase
    end
  end

  // Per-channel history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        recon_mem[i] <= '0;
        older_mem[i] <= '0;
        step_mem[i]  <= '0;
      end
    end else if ((state == ST_WB) && wb_go && !zero_out) begin
      recon_mem[ch_idx] <= w_rec;
      older_mem[ch_idx] <= w_old;
      step_mem[ch_idx]  <= w_st;
    end
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      code_out.valid <= 1'b0;
    end else begin
      // Write-back reloads the output register itself
      if (code_out.valid && code_out.ready && (state != ST_WB)) begin
        code_out.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (sample_in.valid) begin
            cmd   <= sample_in.command;
            chan  <= sample_in.channel;
            smp   <= sample_in.pcm_sample;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          code     <= '0;
          zero_out <= !in_range;
          if (!in_range) begin
            state <= ST_WB;
          end else if (cmd == adpcm_enc_pkg::CMD_LOAD) begin
            w_old <= recon_mem[ch_idx];
            w_rec <= smp;
            w_st  <= step_mem[ch_idx];
            state <= ST_WB;
          end else begin
            w_old <= older_mem[ch_idx];
            if ((mode == adpcm_enc_pkg::MODE_SCALE) && (step_mem[ch_idx] == '0)) begin
              w_rec <= '0;
              w_st  <= adpcm_enc_pkg::SCALE_MIN;
            end else begin
              w_rec <= recon_mem[ch_idx];
              w_st  <= step_mem[ch_idx];
            end
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          dvs <= d_sel;
          neg <= delta[16];
          mag <= delta_mag;
          cnt <= '0;
          if (mode == adpcm_enc_pkg::MODE_IMA_SAR) begin
            rem <= {4'd0, delta_mag};
            dv  <= {3'd0, d_sel, 1'b0};
          end else begin
            rem <= {2'd0, delta_mag, 2'd0};
            dv  <= {1'b0, d_sel, 3'd0};
          end
          state <= (mode == adpcm_enc_pkg::MODE_TWO_TAP) ? ST_PRED1 : ST_DIV;
        end
        ST_PRED1: begin
          state <= ST_PRED2;
        end
        ST_PRED2: begin
          acc   <= 27'(mul_q);
          state <= ST_PRED3;
        end
        ST_PRED3: begin
          acc   <= acc + 27'(mul_q);
          state <= ST_PRED4;
        end
        ST_PRED4: begin
          // Divide by 256, rounding toward zero
          pred  <= acc[26] ? -19'(acc_neg[26:8]) : 19'(acc[26:8]);
          state <= ST_ERR;
        end
        ST_ERR: begin
          neg   <= err[19];
          rem   <= 20'(err_mag) + 20'(dvs >> 1);
          dv    <= {1'b0, dvs, 3'd0};
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (ge) begin
            rem <= rem - dv;
          end
          qb  <= {qb[2:0], ge};
          dv  <= dv >> 1;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= ST_CODE;
          end
        end
        ST_CODE: begin
          if (mode == adpcm_enc_pkg::MODE_TWO_TAP) begin
            qs   <= neg ? -5'(qmag) : 5'(qmag);
            code <= neg ? 4'(-5'(qmag)) : qmag;
          end else begin
            code <= {neg, qb[3] ? 3'd7 : qb[2:0]};
          end
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          state <= ST_RECON;
        end
        ST_RECON: begin
          w_rec <= adpcm_enc_pkg::sat16(rsum);
          if (mode == adpcm_enc_pkg::MODE_TWO_TAP) begin
            w_old <= w_rec;
          end
          if ((mode == adpcm_enc_pkg::MODE_IMA_DIV) || (mode == adpcm_enc_pkg::MODE_IMA_SAR)) begin
            w_st  <= 16'(idx_new);
            state <= ST_WB;
          end else begin
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          state <= ST_STEP;
        end
        ST_STEP: begin
          w_st  <= st_new;
          state <= ST_WB;
        end
        ST_WB: begin
          // Hold until the output register is free
          if (wb_go) begin
            code_out.valid         <= 1'b1;
            code_out.code_nibble   <= zero_out ? '0 : code;
            code_out.reconstructed <= zero_out ? '0 : w_rec;
            code_out.step_value    <= zero_out ? '0 : w_st;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
